### hw/rtl/e2c_pkg.sv
// ============================================================================
// e2c_pkg: shared types and constants for the epoch to calendar converter
// Holds the sequencer state codes, the division phase codes, the reciprocal
// constants, the result type of the shared subtract unit and the month table.
// ============================================================================
package e2c_pkg;

    // Width of the shared compare and subtract unit. The day count never
    // exceeds 49710, so 16 bits cover every operand.
    localparam int OPND_W = 16;
    localparam int REM_W  = 6;

    localparam logic [11:0] BASE_YEAR = 12'd1970;

    // Reciprocals for division by multiplication. The product bits from
    // QUO_LSB upward give the exact quotient for every 32-bit dividend.
    localparam logic [31:0] RECIP_60   = 32'h8888_8889;
    localparam logic [31:0] RECIP_24   = 32'hAAAA_AAAB;
    localparam int          QUO_LSB_60 = 37;
    localparam int          QUO_LSB_24 = 36;

    localparam logic [OPND_W-1:0] QUAD_DAYS       = OPND_W'(1461);
    localparam logic [OPND_W-1:0] LEAP_DAYS       = OPND_W'(366);
    localparam logic [OPND_W-1:0] NORMAL_DAYS     = OPND_W'(365);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_QUAD  = 6'b000100,
        ST_YEAR  = 6'b001000,
        ST_MONTH = 6'b010000,
        ST_DONE  = 6'b100000
    } e2c_state_t;

    typedef enum logic [1:0] {
        DIV_SEC  = 2'd0,
        DIV_MIN  = 2'd1,
        DIV_HOUR = 2'd2,
        DIV_LAST = 2'd3
    } e2c_div_t;

    typedef struct packed {
        logic              ge;
        logic [OPND_W-1:0] diff;
    } e2c_sub_res_t;

    // Length of the month with zero-based index idx; February follows leap.
    function automatic logic [4:0] month_days(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        unique case (idx)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

### hw/rtl/e2c_sub_unit.sv
// ============================================================================
// e2c_sub_unit: shared compare and subtract unit
// Computes a - b together with the a >= b flag; every calendar step of the
// converter (four-year blocks, years, months) goes through it.
// ============================================================================
module e2c_sub_unit (
    input  logic [e2c_pkg::OPND_W-1:0] a,
    input  logic [e2c_pkg::OPND_W-1:0] b,
    output e2c_pkg::e2c_sub_res_t      res
);
    import e2c_pkg::*;

    logic [OPND_W:0] wide;

    // The borrow out of the extended subtraction is the compare result.
    assign wide     = {1'b0, a} - {1'b0, b};
    assign res.ge   = ~wide[OPND_W];
    assign res.diff = wide[OPND_W-1:0];

endmodule

### hw/rtl/epoch_to_calendar.sv
// ============================================================================
// epoch_to_calendar: Unix seconds to calendar date and time
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into second,
// minute, hour, day of month, month and year with one shared subtract unit.
// ============================================================================
// An accepted input word keeps in_ready low until its output word has been
// loaded into the output register, so the block takes no new word before it
// is through with the last. The conversion first splits off the time of
// day: one 32 by 32 bit multiplier is reused for the three divisions by 60,
// 60 and 24 through reciprocal multiplication, and each remainder follows in
// the next division step from the low bits of its dividend.
// The rest of the time is set by the single compare and subtract unit, one
// step per cycle: up to 34 four-year blocks of 1461 days, up to three single
// years and up to eleven months, each walk closed by one compare that fails
// or by reaching December. Every year divisible by four counts as a leap
// year, 2100 included. The finished result sits in an output register, so the
// next input word is taken as soon as that register has been loaded, even
// while out_valid waits for out_ready; a result still waiting there holds the
// following conversion in its last cycle until the receiver takes it.
module epoch_to_calendar (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] unix_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  second_of_minute,
    output logic [5:0]  minute_of_hour,
    output logic [4:0]  hour_of_day,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month_number,
    output logic [11:0] full_year
);
    import e2c_pkg::*;

    // Sequencer and output handshake state.
    e2c_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // Working registers.
    e2c_div_t          div_idx_reg, div_idx_next;
    logic [31:0]       q_reg, q_next;
    logic [REM_W-1:0]  low_reg, low_next;
    logic [REM_W-1:0]  sec_reg, sec_next;
    logic [REM_W-1:0]  min_reg, min_next;
    logic [4:0]        hour_reg, hour_next;
    logic [OPND_W-1:0] days_reg, days_next;
    logic [11:0]       year_reg, year_next;
    logic [3:0]        month_reg, month_next;

    // Output registers.
    logic [5:0]  out_sec_reg;
    logic [5:0]  out_min_reg;
    logic [4:0]  out_hour_reg;
    logic [4:0]  out_day_reg;
    logic [3:0]  out_month_reg;
    logic [11:0] out_year_reg;

    logic              load_out;
    logic              leap;
    logic [31:0]       recip;
    logic [63:0]       product;
    logic [31:0]       quotient;
    logic [REM_W-1:0]  rem_60;
    logic [4:0]        rem_24;
    logic [OPND_W-1:0] unit_a;
    logic [OPND_W-1:0] unit_b;
    e2c_sub_res_t      unit_res;

    assign leap = (year_reg[1:0] == 2'b00);

    // Shared multiplier for the three divisions. The dividend sits in q_reg
    // and is replaced by its quotient at every division step.
    assign recip    = (div_idx_reg == DIV_HOUR) ? RECIP_24 : RECIP_60;
    assign product  = {32'd0, q_reg} * {32'd0, recip};
    assign quotient = (div_idx_reg == DIV_HOUR)
                    ? {{(QUO_LSB_24 - 32){1'b0}}, product[63:QUO_LSB_24]}
                    : {{(QUO_LSB_60 - 32){1'b0}}, product[63:QUO_LSB_60]};

    // A remainder is below 64, so only low bits matter. Since 60 is -4
    // modulo 64 and 24 is -8 modulo 32, it is the low bits of the dividend
    // plus a small multiple of the quotient that now sits in q_reg.
    assign rem_60 = low_reg + {q_reg[3:0], 2'b00};
    assign rem_24 = low_reg[4:0] + {q_reg[1:0], 3'b000};

    // Operand selection for the shared unit. The day count is always the
    // minuend; the subtrahend depends on which walk is running.
    always_comb
    begin
        unit_a = days_reg;
        unit_b = QUAD_DAYS;
        unique case (state_reg)
            ST_QUAD:
            begin
                unit_b = QUAD_DAYS;
            end
            ST_YEAR:
            begin
                unit_b = leap ? LEAP_DAYS : NORMAL_DAYS;
            end
            ST_MONTH:
            begin
                unit_b = OPND_W'(month_days(month_reg, leap));
            end
            default:
            begin
                unit_b = QUAD_DAYS;
            end
        endcase
    end

    e2c_sub_unit u_sub (
        .a   (unit_a),
        .b   (unit_b),
        .res (unit_res)
    );

    // Sequencer. A four-year block starting at 1970 always holds 1461 days,
    // so whole blocks are removed first and single years only at the end.
    always_comb
    begin
        state_next   = state_reg;
        div_idx_next = div_idx_reg;
        q_next       = q_reg;
        low_next     = low_reg;
        sec_next     = sec_reg;
        min_next     = min_reg;
        hour_next    = hour_reg;
        days_next    = days_reg;
        year_next    = year_reg;
        month_next   = month_reg;
        load_out     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    q_next       = unix_time;
                    div_idx_next = DIV_SEC;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // Each step divides q_reg and keeps the dividend's low bits,
                // while the remainder of the step before is completed.
                q_next   = quotient;
                low_next = q_reg[REM_W-1:0];
                unique case (div_idx_reg)
                    DIV_SEC:
                    begin
                        div_idx_next = DIV_MIN;
                    end
                    DIV_MIN:
                    begin
                        sec_next     = rem_60;
                        div_idx_next = DIV_HOUR;
                    end
                    DIV_HOUR:
                    begin
                        min_next     = rem_60;
                        div_idx_next = DIV_LAST;
                    end
                    DIV_LAST:
                    begin
                        hour_next  = rem_24;
                        days_next  = q_reg[OPND_W-1:0];
                        year_next  = BASE_YEAR;
                        state_next = ST_QUAD;
                    end
                endcase
            end
            ST_QUAD:
            begin
                if (unit_res.ge)
                begin
                    days_next = unit_res.diff;
                    year_next = year_reg + 12'd4;
                end
                else
                begin
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                if (unit_res.ge)
                begin
                    days_next = unit_res.diff;
                    year_next = year_reg + 12'd1;
                end
                else
                begin
                    month_next = '0;
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                if (unit_res.ge && (month_reg != 4'd11))
                begin
                    days_next  = unit_res.diff;
                    month_next = month_reg + 4'd1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_idx_reg <= div_idx_next;
        q_reg       <= q_next;
        low_reg     <= low_next;
        sec_reg     <= sec_next;
        min_reg     <= min_next;
        hour_reg    <= hour_next;
        days_reg    <= days_next;
        year_reg    <= year_next;
        month_reg   <= month_next;
        if (load_out)
        begin
            out_sec_reg   <= sec_reg;
            out_min_reg   <= min_reg;
            out_hour_reg  <= hour_reg;
            out_day_reg   <= days_reg[4:0] + 5'd1;
            out_month_reg <= month_reg + 4'd1;
            out_year_reg  <= year_reg;
        end
    end

    assign in_ready         = (state_reg == ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign second_of_minute = out_sec_reg;
    assign minute_of_hour   = out_min_reg;
    assign hour_of_day      = out_hour_reg;
    assign day_of_month     = out_day_reg;
    assign month_number     = out_month_reg;
    assign full_year        = out_year_reg;

`ifndef SYNTH
    // An accepted word starts the division at once and blocks further input.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DIV) && !in_ready)
        else $error("accepted word did not start the division");

    // The time of day split is complete and in range once the year walk runs.
    a_tod_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_YEAR) |-> (sec_reg < 6'd60) && (min_reg < 6'd60)
                                   && (hour_reg < 5'd24))
        else $error("time of day working value out of range");

    // Once the year loop has finished, fewer days remain than a year holds.
    a_days_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MONTH) |-> (days_reg < LEAP_DAYS))
        else $error("day count left for the month walk exceeds a year");

    // Delivered time of day fields are in range.
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (second_of_minute < 6'd60) && (minute_of_hour < 6'd60)
                      && (hour_of_day < 5'd24))
        else $error("time of day field out of range");

    // Delivered date fields are in range.
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month_number >= 4'd1) && (month_number <= 4'd12)
                      && (day_of_month >= 5'd1) && (full_year >= BASE_YEAR)
                      && (full_year <= 12'd2106))
        else $error("date field out of range");
`endif

endmodule

### tb/tb_epoch_to_calendar.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_epoch_to_calendar: self-checking bench for the epoch to calendar converter
// Feeds seconds counts through the valid/ready input, predicts the calendar
// word for each one and checks every output word in order, field by field.
// ============================================================================
module tb_epoch_to_calendar;

    localparam int CLK_PERIOD   = 12;
    // The slowest legal run is about 1950 words, each with its longest
    // conversion, its longest send gap and its longest output stall, plus the
    // long output hold-off. The limit leaves a wide margin above that.
    localparam int CYCLE_LIMIT  = 1_500_000;
    // The drain after the last expected word covers any word that might still
    // be on its way.
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 1200;
    localparam int PRINT_LIMIT  = 30;

    // One predicted calendar word, together with the seconds count it came from.
    typedef struct {
        logic [31:0] secs;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  mday;
        logic [3:0]  month;
        logic [11:0] year;
    } calendar_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic [31:0] unix_time     = '0;
    logic        out_ready     = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_of_day;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [11:0] full_year;

    // Predicted words, oldest first, waiting for the block to produce them.
    calendar_t pending_dates[$];

    bit idling_on   = 1'b1;
    bit hold_active = 1'b0;
    int ready_stall = 0;
    int cycle_count = 0;
    int error_count = 0;
    int words_sent  = 0;
    int words_seen  = 0;
    int year_low    = 4095;
    int year_high   = 0;

    epoch_to_calendar u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .unix_time        (unix_time),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .day_of_month     (day_of_month),
        .month_number     (month_number),
        .full_year        (full_year)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Calendar arithmetic used by the prediction and by the stimulus.
    // ------------------------------------------------------------------------

    // The block uses the plain rule: every fourth year is a leap year, so
    // 2100 gets a 29th of February too.
    function automatic bit is_leap(input int yr);
        return (yr % 4) == 0;
    endfunction

    function automatic int month_length(input int mo, input bit leap);
        case (mo)
            2:             return leap ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Seconds count for a calendar date and time under the same leap rule.
    // The result can exceed 32 bits for dates past early 2106.
    function automatic longint epoch_of(input int yr, input int mo, input int dd,
                                        input int hh, input int mi, input int ss);
        longint days;
        int     y;
        int     m;
        days = dd - 1;
        for (y = 1970; y < yr; y++)
            days += is_leap(y) ? 366 : 365;
        for (m = 1; m < mo; m++)
            days += month_length(m, is_leap(yr));
        return ((days * 24 + hh) * 60 + mi) * 60 + ss;
    endfunction

    // Splits a seconds count into the calendar word the block should return.
    // Time of day comes off first, then whole years starting at 1970, then
    // whole months; whatever is left is the zero-based day of the month.
    function automatic calendar_t calendar_of(input logic [31:0] secs);
        calendar_t   cal;
        int unsigned rest;
        int unsigned days;
        int unsigned yr;
        int unsigned mo;
        int unsigned len;
        cal.secs   = secs;
        rest       = secs;
        cal.second = 6'(rest % 60);
        rest       = rest / 60;
        cal.minute = 6'(rest % 60);
        rest       = rest / 60;
        cal.hour   = 5'(rest % 24);
        days       = rest / 24;
        yr  = 1970;
        len = is_leap(yr) ? 366 : 365;
        while (days >= len)
        begin
            days -= len;
            yr++;
            len = is_leap(yr) ? 366 : 365;
        end
        mo  = 1;
        len = month_length(mo, is_leap(yr));
        while (mo < 12 && days >= len)
        begin
            days -= len;
            mo++;
            len = month_length(mo, is_leap(yr));
        end
        cal.mday  = 5'(days + 1);
        cal.month = 4'(mo);
        cal.year  = 12'(yr);
        return cal;
    endfunction

    // A count within a second of the first or last second of the first or last
    // day of a random month, so many land next to a month or year change. Counts
    // that land past the 32-bit range are pulled back just under the top.
    function automatic logic [31:0] boundary_word();
        int     yr;
        int     mo;
        int     dd;
        longint secs;
        yr = $urandom_range(1970, 2106);
        mo = $urandom_range(1, 12);
        dd = ($urandom_range(0, 1) == 0) ? 1 : month_length(mo, is_leap(yr));
        if ($urandom_range(0, 1) == 0)
            secs = epoch_of(yr, mo, dd, 0, 0, 0) + int'($urandom_range(0, 2)) - 1;
        else
            secs = epoch_of(yr, mo, dd, 23, 59, 59) + int'($urandom_range(0, 2)) - 1;
        if (secs < 0)
            secs = 0;
        if (secs > 64'sd4294967295)
            return 32'hFFFF_FFFF - $urandom_range(0, 100000);
        return 32'(secs);
    endfunction

    // Idle length for either side: mostly none, often a few cycles, now and
    // then a long pause. With idling switched off both sides run flat out.
    function automatic int pick_gap();
        int roll;
        if (!idling_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Input side: one shared task offers a word and waits for the handshake.
    // ------------------------------------------------------------------------

    // Valid is only dropped when a gap follows, so a word that comes straight
    // after the previous one keeps valid high through the handshake edge.
    task automatic send_word(input logic [31:0] secs);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        unix_time <= secs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_dates.push_back(calendar_of(secs));
        words_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Output side: checking of each accepted word and the ready pattern.
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] secs,
                                   input int got, input int want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("MISMATCH %s at %0t: epoch %0d, got %0d, expected %0d",
                     what, $realtime, secs, got, want);
    endtask

    task automatic check_word();
        calendar_t want;
        if (pending_dates.size() == 0)
        begin
            report_mismatch("word with nothing pending", 32'd0, full_year, 0);
            return;
        end
        want = pending_dates.pop_front();
        words_seen++;
        if (want.year < year_low)
            year_low = want.year;
        if (want.year > year_high)
            year_high = want.year;
        if (second_of_minute !== want.second)
            report_mismatch("second_of_minute", want.secs, second_of_minute, want.second);
        if (minute_of_hour !== want.minute)
            report_mismatch("minute_of_hour", want.secs, minute_of_hour, want.minute);
        if (hour_of_day !== want.hour)
            report_mismatch("hour_of_day", want.secs, hour_of_day, want.hour);
        if (day_of_month !== want.mday)
            report_mismatch("day_of_month", want.secs, day_of_month, want.mday);
        if (month_number !== want.month)
            report_mismatch("month_number", want.secs, month_number, want.month);
        if (full_year !== want.year)
            report_mismatch("full_year", want.secs, full_year, want.year);
    endtask

    // Samples the handshake at the edge, then decides ready for the next
    // cycle. A pending hold-off overrides the random stalls.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_word();
            if (hold_active)
                out_ready <= 1'b0;
            else if (ready_stall > 0)
            begin
                ready_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                ready_stall = pick_gap();
                out_ready <= (ready_stall == 0);
            end
        end
    end

    // Watchdog: a run that hangs ends here as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d words still pending",
                     cycle_count, pending_dates.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Edges of the time of day, the first year change, leap and plain
    // Februaries, the year 2100 treated as a leap year, and the extreme
    // and alternating bit patterns up to the largest count.
    task automatic test_directed_corners();
        send_word(32'd0);
        send_word(32'd59);
        send_word(32'd60);
        send_word(32'd3599);
        send_word(32'd3600);
        send_word(32'd86399);
        send_word(32'd86400);
        send_word(32'(epoch_of(1970, 12, 31, 23, 59, 59)));
        send_word(32'(epoch_of(1971, 1, 1, 0, 0, 0)));
        send_word(32'(epoch_of(1972, 2, 28, 23, 59, 59)));
        send_word(32'(epoch_of(1972, 2, 29, 23, 59, 59)));
        send_word(32'(epoch_of(1972, 3, 1, 0, 0, 0)));
        send_word(32'(epoch_of(1973, 2, 28, 23, 59, 59)));
        send_word(32'(epoch_of(1973, 3, 1, 0, 0, 0)));
        send_word(32'(epoch_of(2100, 2, 29, 12, 0, 0)));
        send_word(32'(epoch_of(2100, 12, 31, 23, 59, 59)));
        send_word(32'(epoch_of(2101, 1, 1, 0, 0, 0)));
        send_word(32'h7FFF_FFFF);
        send_word(32'h8000_0000);
        send_word(32'hAAAA_AAAA);
        send_word(32'h5555_5555);
        send_word(32'hFFFF_FFFE);
        send_word(32'hFFFF_FFFF);
    endtask

    // Mostly uniform counts, with some month and year edges mixed in.
    task automatic test_random_mix(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 7)
                send_word($urandom());
            else
                send_word(boundary_word());
        end
    endtask

    // No gaps and no stalls: each word is offered the moment the block can
    // take it and every result leaves on its first cycle.
    task automatic test_back_to_back(input int count);
        int i;
        idling_on = 1'b0;
        for (i = 0; i < count; i++)
            send_word($urandom());
        idling_on = 1'b1;
    endtask

    // The receiver holds ready low for a long stretch while the sender keeps
    // offering words, so the output register and the converter both fill and
    // the input has to stall until the hold is released.
    task automatic test_output_backpressure();
        int i;
        fork
            begin
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end
        join_none
        for (i = 0; i < 12; i++)
            send_word($urandom());
    endtask

    // Dense sweep of month and year changes across the whole range of years.
    task automatic test_month_boundaries(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_word(boundary_word());
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_random_mix(900);
        test_back_to_back(300);
        test_output_backpressure();
        test_month_boundaries(700);
        in_valid <= 1'b0;

        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d words and checked %0d results, years %0d to %0d,",
                 words_sent, words_seen, year_low, year_high);
        $display("with random idling, a flat-out stretch and a %0d-cycle output hold.",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### epoch_to_calendar.f
hw/rtl/e2c_pkg.sv
hw/rtl/e2c_sub_unit.sv
hw/rtl/epoch_to_calendar.sv
tb/tb_epoch_to_calendar.sv
